@@ src/joystick_frame_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// Joystick frame encoder assertion macros
// Shared concurrent assertion forms for the encoder and its divider.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_FRAME_ENCODER_MACROS_SVH
`define JOYSTICK_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define JFE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define JFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/jfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick frame encoder package
// Widths, register indexes, byte tags, sequencer states and divider types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jfe_pkg;

	// Parameter defaults
	localparam int ROUNDS_DEFAULT   = 10;
	localparam int ADC_BITS_DEFAULT = 12;

	// Datapath widths
	localparam int SUM_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_W     = 22;   // 63 * |sum - offset|
	localparam int DEN_W     = 17;   // 2 * range
	localparam int QUO_W     = 7;    // quotient bits, enough to see saturation
	localparam int STEP_W    = 3;
	localparam int FIELD_W   = 5;
	localparam int TAG_W     = 3;
	localparam int BYTE_W    = 8;

	localparam int AXIS_LIMIT     = 15;
	localparam int THROTTLE_LIMIT = 31;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_RANGE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y_RANGE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_RANGE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_RANGE = 3'd7;

	localparam logic [CFG_W-1:0] CFG_OFFSET_RESET = 16'd20475;
	localparam logic [CFG_W-1:0] CFG_RANGE_RESET  = 16'd40950;
	localparam logic [CFG_W-1:0] CFG_MIN_RESET    = 16'd0;

	// Axis codes for the sequencer
	localparam logic [1:0] AXIS_LEFT_X  = 2'd0;
	localparam logic [1:0] AXIS_LEFT_Y  = 2'd1;
	localparam logic [1:0] AXIS_RIGHT_X = 2'd2;
	localparam logic [1:0] AXIS_THROTTLE = 2'd3;

	// Frame byte tags
	localparam logic [TAG_W-1:0] TAG_LEFT_X   = 3'd0;
	localparam logic [TAG_W-1:0] TAG_LEFT_Y   = 3'd1;
	localparam logic [TAG_W-1:0] TAG_RIGHT_X  = 3'd2;
	localparam logic [TAG_W-1:0] TAG_THROTTLE = 3'd3;
	localparam logic [TAG_W-1:0] TAG_SWITCH   = 3'd4;
	localparam logic [TAG_W-1:0] TAG_DIAL     = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} jfe_state_t;

	typedef struct packed {
		logic start;
	} jfe_div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} jfe_div_stat_t;

endpackage

`default_nettype wire

@@ src/jfe_divider.sv @@
// ----------------------------------------------------------------------------
// Joystick frame encoder divider
// Restoring divider, one quotient bit per cycle, quotient saturates by width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_frame_encoder_macros.svh"

module jfe_divider
	import jfe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire jfe_div_ctrl_t      ctrl,
	input  wire logic [NUM_W-1:0]   num,
	input  wire logic [DEN_W-1:0]   den,
	output logic      [QUO_W-1:0]   quo,
	output jfe_div_stat_t           stat
);

	localparam int DSH_W = DEN_W + QUO_W - 1;

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [NUM_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic               hit;

	// Compare the remainder against the shifted divisor
	assign hit = {{(DSH_W-NUM_W){1'b0}}, rem_q} >= dsh_q;

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q - 1'b1;
			end
		end
	end

	// Shift and subtract
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= num;
			dsh_q <= {den, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (hit) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], hit};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`JFE_ASSERT_IMPL(a_div_start_idle, clk, arst_n, ctrl.start, !busy_q, "divider started while busy")
	`JFE_ASSERT_IMPL(a_div_done_idle, clk, arst_n, done_q, !busy_q, "divider done while busy")
	`JFE_ASSERT_NEXT(a_div_last_step, clk, arst_n, busy_q && (step_q == '0) && !ctrl.start, done_q, "divider missed done")

endmodule

`default_nettype wire

@@ src/joystick_frame_encoder.sv @@
// Requests are taken only while the sequencer is idle; rounds before the last of a frame give no bytes.
// On the last round the shared divider runs for each of four axes in turn (operand load,
// 7 quotient bits, store), then six bytes leave at one per cycle while the sink does not stall.
// A frame round thus holds the input until the last of the six bytes is loaded for output.
// Reset clears sums, round count, sequencer and output valid, and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Joystick frame encoder
// Sums ADC rounds per axis, scales them through a shared divider, emits frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_frame_encoder_macros.svh"

module joystick_frame_encoder
	import jfe_pkg::*;
#(
	parameter int ROUNDS_PER_FRAME = ROUNDS_DEFAULT,
	parameter int ADC_BITS         = ADC_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [ADC_BITS-1:0]   sample_left_x,
	input  wire logic [ADC_BITS-1:0]   sample_left_y,
	input  wire logic [ADC_BITS-1:0]   sample_right_x,
	input  wire logic [ADC_BITS-1:0]   sample_throttle,
	input  wire logic                  switch_one_level,
	input  wire logic                  switch_two_level,
	input  wire logic [1:0]            dial_one,
	input  wire logic [2:0]            dial_two,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [BYTE_W-1:0]     tx_byte,
	output logic                       last_byte,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(ROUNDS_PER_FRAME + 1);
	localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUNDS_PER_FRAME);

	jfe_state_t          state_q, state_d;
	logic [CFG_W-1:0]    cfg_q [CFG_COUNT];
	logic [SUM_W-1:0]    sum_lx_q, sum_ly_q, sum_rx_q, sum_th_q;
	logic [CNT_W-1:0]    round_q;
	logic [CNT_W-1:0]    round_next;
	logic                final_round;
	logic                in_accept;
	logic [1:0]          axis_q;
	logic                neg_q;
	logic [FIELD_W-1:0]  field_q [4];
	logic                sw_one_q, sw_two_q;
	logic [1:0]          dial_one_q;
	logic [2:0]          dial_two_q;
	logic [TAG_W-1:0]    byte_idx_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   tx_byte_q;
	logic                last_byte_q;

	logic                axis_done;
	logic                emit_load;
	logic [SUM_W-1:0]    sum_sel;
	logic [CFG_W-1:0]    off_sel, rng_sel;
	logic                neg_sel;
	logic [SUM_W-1:0]    abs_diff;
	logic [NUM_W-1:0]    num;
	logic [DEN_W-1:0]    den;
	logic [QUO_W-1:0]    quo;
	logic [3:0]          clip_axis;
	logic [FIELD_W-1:0]  field_val;
	logic [FIELD_W-1:0]  emit_payload;

	jfe_div_ctrl_t       div_ctrl;
	jfe_div_stat_t       div_stat;

	assign in_accept   = in_valid && !in_stall;
	assign round_next  = round_q + 1'b1;
	assign final_round = (round_next == LAST_ROUND);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_LEFT_X_OFFSET]  <= CFG_OFFSET_RESET;
			cfg_q[REG_LEFT_X_RANGE]   <= CFG_RANGE_RESET;
			cfg_q[REG_LEFT_Y_OFFSET]  <= CFG_OFFSET_RESET;
			cfg_q[REG_LEFT_Y_RANGE]   <= CFG_RANGE_RESET;
			cfg_q[REG_RIGHT_X_OFFSET] <= CFG_OFFSET_RESET;
			cfg_q[REG_RIGHT_X_RANGE]  <= CFG_RANGE_RESET;
			cfg_q[REG_THROTTLE_MIN]   <= CFG_MIN_RESET;
			cfg_q[REG_THROTTLE_RANGE] <= CFG_RANGE_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Accumulate rounds, clear after the last axis is scaled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_lx_q <= '0;
			sum_ly_q <= '0;
			sum_rx_q <= '0;
			sum_th_q <= '0;
			round_q  <= '0;
		end else if (in_accept) begin
			sum_lx_q <= sum_lx_q + SUM_W'(sample_left_x);
			sum_ly_q <= sum_ly_q + SUM_W'(sample_left_y);
			sum_rx_q <= sum_rx_q + SUM_W'(sample_right_x);
			sum_th_q <= sum_th_q + SUM_W'(sample_throttle);
			round_q  <= final_round ? '0 : round_next;
		end else if (axis_done && (axis_q == AXIS_THROTTLE)) begin
			sum_lx_q <= '0;
			sum_ly_q <= '0;
			sum_rx_q <= '0;
			sum_th_q <= '0;
		end
	end

	// Hold switch and dial levels of the latest round
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sw_one_q   <= switch_one_level;
			sw_two_q   <= switch_two_level;
			dial_one_q <= dial_one;
			dial_two_q <= dial_two;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && final_round) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = (axis_q == AXIS_THROTTLE) ? ST_EMIT : ST_LOAD;
				end
			end
			ST_EMIT: begin
				if (emit_load && (byte_idx_q == TAG_DIAL)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		div_ctrl.start = (state_q == ST_LOAD);
		axis_done      = (state_q == ST_DIV) && div_stat.done;
		emit_load      = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_q     <= AXIS_LEFT_X;
			byte_idx_q <= TAG_LEFT_X;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				axis_q     <= AXIS_LEFT_X;
				byte_idx_q <= TAG_LEFT_X;
			end else begin
				if (axis_done) begin
					axis_q <= axis_q + 1'b1;
				end
				if (emit_load) begin
					byte_idx_q <= byte_idx_q + 1'b1;
				end
			end
		end
	end

	// Select operands for the current axis
	always_comb begin
		unique case (axis_q)
			AXIS_LEFT_X: begin
				sum_sel = sum_lx_q;
				off_sel = cfg_q[REG_LEFT_X_OFFSET];
				rng_sel = cfg_q[REG_LEFT_X_RANGE];
			end
			AXIS_LEFT_Y: begin
				sum_sel = sum_ly_q;
				off_sel = cfg_q[REG_LEFT_Y_OFFSET];
				rng_sel = cfg_q[REG_LEFT_Y_RANGE];
			end
			AXIS_RIGHT_X: begin
				sum_sel = sum_rx_q;
				off_sel = cfg_q[REG_RIGHT_X_OFFSET];
				rng_sel = cfg_q[REG_RIGHT_X_RANGE];
			end
			default: begin
				sum_sel = sum_th_q;
				off_sel = cfg_q[REG_THROTTLE_MIN];
				rng_sel = cfg_q[REG_THROTTLE_RANGE];
			end
		endcase
	end

	// Split into sign and magnitude; 63*x as (x << 6) - x; a zero range counts as one
	assign neg_sel  = (sum_sel < off_sel);
	assign abs_diff = neg_sel ? (off_sel - sum_sel) : (sum_sel - off_sel);
	assign num      = {abs_diff, 6'b000000} - NUM_W'(abs_diff);
	assign den      = (rng_sel == '0) ? DEN_W'(2) : {rng_sel, 1'b0};

	always_ff @(posedge clk) begin
		if (div_ctrl.start) begin
			neg_q <= neg_sel;
		end
	end

	jfe_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.num    (num),
		.den    (den),
		.quo    (quo),
		.stat   (div_stat)
	);

	// Clamp the quotient and apply the sign
	always_comb begin
		clip_axis = (quo > QUO_W'(AXIS_LIMIT)) ? 4'(AXIS_LIMIT) : quo[3:0];
		if (axis_q == AXIS_THROTTLE) begin
			if (neg_q) begin
				field_val = '0;
			end else if (quo > QUO_W'(THROTTLE_LIMIT)) begin
				field_val = FIELD_W'(THROTTLE_LIMIT);
			end else begin
				field_val = quo[FIELD_W-1:0];
			end
		end else if (neg_q) begin
			field_val = FIELD_W'(AXIS_LIMIT) - {1'b0, clip_axis};
		end else begin
			field_val = FIELD_W'(AXIS_LIMIT) + {1'b0, clip_axis};
		end
	end

	always_ff @(posedge clk) begin
		if (axis_done) begin
			field_q[axis_q] <= field_val;
		end
	end

	// Build the payload of the next frame byte
	always_comb begin
		unique case (byte_idx_q)
			TAG_LEFT_X, TAG_LEFT_Y, TAG_RIGHT_X, TAG_THROTTLE: begin
				emit_payload = field_q[byte_idx_q[1:0]];
			end
			TAG_SWITCH: begin
				emit_payload = {3'b000, ~sw_one_q, ~sw_two_q};
			end
			TAG_DIAL: begin
				emit_payload = {dial_two_q, dial_one_q};
			end
			default: begin
				emit_payload = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			tx_byte_q   <= {byte_idx_q, emit_payload};
			last_byte_q <= (byte_idx_q == TAG_DIAL);
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last_byte = last_byte_q;

	`JFE_ASSERT_IMPL(a_last_is_dial, clk, arst_n, out_valid_q && last_byte_q, tx_byte_q[7:5] == TAG_DIAL, "last byte without dial tag")
	`JFE_ASSERT_NEXT(a_frame_starts, clk, arst_n, in_accept && final_round, (state_q == ST_LOAD) && (axis_q == AXIS_LEFT_X), "frame round did not start scaling")
	`JFE_ASSERT_IMPL(a_done_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV, "divider result outside divide state")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick frame encoder testbench
// Feeds rounds of ADC samples through bursty requests while the byte sink
// stalls on its own pattern. A scoreboard rebuilds each frame from the
// accepted rounds and the register settings, then checks every output byte.
// ----------------------------------------------------------------------------
module testbench
	import jfe_pkg::*;
();

	localparam int CLK_HALF       = 5;
	localparam int ADC_W          = ADC_BITS_DEFAULT;
	localparam int ROUNDS         = ROUNDS_DEFAULT;
	localparam int ADC_MAX        = (1 << ADC_W) - 1;
	localparam int FULL_SCALE_SUM = ROUNDS * ADC_MAX;
	localparam int SCALE_NUM      = 63;
	localparam int JITTER         = 40;
	localparam int ZERO_SPAN_MID  = 20470;
	localparam int ITEM_TARGET    = 310;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LIMIT    = 3000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [ADC_W-1:0] left_x;
		logic [ADC_W-1:0] left_y;
		logic [ADC_W-1:0] right_x;
		logic [ADC_W-1:0] throttle;
		logic             switch_one;
		logic             switch_two;
		logic [1:0]       dial_one;
		logic [2:0]       dial_two;
	} adc_round_t;

	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              last;
	} frame_byte_t;

	typedef enum {ROUND_SPREAD, ROUND_HELD, ROUND_RAILS} round_style_t;
	typedef enum {SET_TRIMMED, SET_EXTREME, SET_WILD} setting_style_t;
	typedef enum {RX_FREE, RX_COIN, RX_LIGHT, RX_BURSTY} rx_pattern_t;

	logic                 clk              = 1'b0;
	logic                 arst_n           = 1'b0;
	logic                 in_valid         = 1'b0;
	logic                 in_stall;
	logic [ADC_W-1:0]     sample_left_x    = '0;
	logic [ADC_W-1:0]     sample_left_y    = '0;
	logic [ADC_W-1:0]     sample_right_x   = '0;
	logic [ADC_W-1:0]     sample_throttle  = '0;
	logic                 switch_one_level = 1'b1;
	logic                 switch_two_level = 1'b1;
	logic [1:0]           dial_one         = '0;
	logic [2:0]           dial_two         = '0;
	logic                 out_valid;
	logic                 out_stall        = 1'b0;
	logic [BYTE_W-1:0]    tx_byte;
	logic                 last_byte;
	logic                 cfg_we           = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index        = '0;
	logic [CFG_W-1:0]     cfg_data         = '0;

	// Scoreboard copy of the block state
	logic [CFG_W-1:0] cal_regs [CFG_COUNT];
	logic [CFG_W-1:0] next_setting [CFG_COUNT];
	logic [SUM_W-1:0] acc_left_x   = '0;
	logic [SUM_W-1:0] acc_left_y   = '0;
	logic [SUM_W-1:0] acc_right_x  = '0;
	logic [SUM_W-1:0] acc_throttle = '0;
	int               rounds_in_frame = 0;

	adc_round_t  round_queue [$];
	frame_byte_t frame_bytes_due [$];
	adc_round_t  next_round;
	frame_byte_t due;

	int items_queued     = 0;
	int rounds_taken     = 0;
	int bytes_checked    = 0;
	int settings_applied = 0;
	int failures         = 0;
	int quiet_cycles     = 0;
	int gap_left         = 0;
	int burst_left       = 0;
	int hold_left        = 0;
	int pattern_left     = 0;
	bit hold_pending     = 1'b0;
	rx_pattern_t rx_pattern = RX_FREE;

	joystick_frame_encoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample_left_x    (sample_left_x),
		.sample_left_y    (sample_left_y),
		.sample_right_x   (sample_right_x),
		.sample_throttle  (sample_throttle),
		.switch_one_level (switch_one_level),
		.switch_two_level (switch_two_level),
		.dial_one         (dial_one),
		.dial_two         (dial_two),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.tx_byte          (tx_byte),
		.last_byte        (last_byte),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic bit is_span(logic [CFG_IDX_W-1:0] idx);
		case (idx)
			REG_LEFT_X_RANGE, REG_LEFT_Y_RANGE, REG_RIGHT_X_RANGE, REG_THROTTLE_RANGE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Scale one summed axis against its centre and span, truncate toward zero, clamp
	function automatic int axis_position(logic [SUM_W-1:0] acc, logic [CFG_W-1:0] centre,
			logic [CFG_W-1:0] span, int lo, int hi);
		longint acc_l;
		longint centre_l;
		longint span_l;
		longint den;
		longint pos;
		acc_l    = acc;
		centre_l = centre;
		span_l   = span;
		den      = (span_l == 0) ? 2 : 2 * span_l;
		pos      = (SCALE_NUM * (acc_l - centre_l)) / den;
		if (pos > hi)
			return hi;
		if (pos < lo)
			return lo;
		return int'(pos);
	endfunction

	// Add one accepted round; on the last round of a frame, queue its six bytes
	task automatic accumulate_round(adc_round_t r);
		int lx;
		int ly;
		int rx;
		int th;
		acc_left_x   = acc_left_x + r.left_x;
		acc_left_y   = acc_left_y + r.left_y;
		acc_right_x  = acc_right_x + r.right_x;
		acc_throttle = acc_throttle + r.throttle;
		rounds_in_frame++;
		if (rounds_in_frame >= ROUNDS) begin
			lx = axis_position(acc_left_x, cal_regs[REG_LEFT_X_OFFSET],
				cal_regs[REG_LEFT_X_RANGE], -AXIS_LIMIT, AXIS_LIMIT);
			ly = axis_position(acc_left_y, cal_regs[REG_LEFT_Y_OFFSET],
				cal_regs[REG_LEFT_Y_RANGE], -AXIS_LIMIT, AXIS_LIMIT);
			rx = axis_position(acc_right_x, cal_regs[REG_RIGHT_X_OFFSET],
				cal_regs[REG_RIGHT_X_RANGE], -AXIS_LIMIT, AXIS_LIMIT);
			th = axis_position(acc_throttle, cal_regs[REG_THROTTLE_MIN],
				cal_regs[REG_THROTTLE_RANGE], 0, THROTTLE_LIMIT);
			frame_bytes_due.push_back({TAG_LEFT_X, FIELD_W'(lx + AXIS_LIMIT), 1'b0});
			frame_bytes_due.push_back({TAG_LEFT_Y, FIELD_W'(ly + AXIS_LIMIT), 1'b0});
			frame_bytes_due.push_back({TAG_RIGHT_X, FIELD_W'(rx + AXIS_LIMIT), 1'b0});
			frame_bytes_due.push_back({TAG_THROTTLE, FIELD_W'(th), 1'b0});
			frame_bytes_due.push_back({TAG_SWITCH, 3'b000, ~r.switch_one, ~r.switch_two, 1'b0});
			frame_bytes_due.push_back({TAG_DIAL, r.dial_two, r.dial_one, 1'b1});
			acc_left_x      = '0;
			acc_left_y      = '0;
			acc_right_x     = '0;
			acc_throttle    = '0;
			rounds_in_frame = 0;
		end
	endtask

	function automatic void log_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	function automatic logic [ADC_W-1:0] sample_for(round_style_t style, int base);
		int v;
		case (style)
			ROUND_HELD:  v = base + int'($urandom_range(0, 2 * JITTER)) - JITTER;
			ROUND_RAILS: v = $urandom_range(0, 1) ? ADC_MAX : 0;
			default:     v = $urandom_range(0, ADC_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return ADC_W'(v);
	endfunction

	function automatic logic [CFG_W-1:0] pick_setting(logic [CFG_IDX_W-1:0] idx,
			setting_style_t style);
		case (style)
			SET_TRIMMED: begin
				if (is_span(idx))
					return CFG_W'($urandom_range(30000, 45000));
				if (idx == REG_THROTTLE_MIN)
					return CFG_W'($urandom_range(0, 3000));
				return CFG_W'($urandom_range(17500, 23500));
			end
			SET_EXTREME: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return CFG_W'(1);
					2:       return CFG_W'(FULL_SCALE_SUM);
					default: return '1;
				endcase
			end
			default: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
		endcase
	endfunction

	task automatic push_round(int lx, int ly, int rx, int th, int s1, int s2, int d1, int d2);
		adc_round_t r;
		r.left_x     = ADC_W'(lx);
		r.left_y     = ADC_W'(ly);
		r.right_x    = ADC_W'(rx);
		r.throttle   = ADC_W'(th);
		r.switch_one = 1'(s1);
		r.switch_two = 1'(s2);
		r.dial_one   = 2'(d1);
		r.dial_two   = 3'(d2);
		round_queue.push_back(r);
		items_queued++;
	endtask

	task automatic queue_rounds(round_style_t style, int count);
		adc_round_t r;
		int base [4];
		for (int k = 0; k < 4; k++)
			base[k] = $urandom_range(0, ADC_MAX);
		for (int n = 0; n < count; n++) begin
			r.left_x     = sample_for(style, base[0]);
			r.left_y     = sample_for(style, base[1]);
			r.right_x    = sample_for(style, base[2]);
			r.throttle   = sample_for(style, base[3]);
			r.switch_one = 1'($urandom_range(0, 1));
			r.switch_two = 1'($urandom_range(0, 1));
			r.dial_one   = 2'($urandom_range(0, 3));
			r.dial_two   = 3'($urandom_range(0, 7));
			round_queue.push_back(r);
			items_queued++;
		end
	endtask

	// Wait until every request is taken and every byte has come, then let the block go quiet
	task automatic settle_block();
		while (round_queue.size() != 0 || in_valid || frame_bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all registers from next_setting; only called while the block is idle
	task automatic program_registers();
		for (int idx = 0; idx < CFG_COUNT; idx++) begin
			@(posedge clk);
			cfg_we        <= 1'b1;
			cfg_index     <= CFG_IDX_W'(idx);
			cfg_data      <= next_setting[idx];
			cal_regs[idx] = next_setting[idx];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (round_queue.size() != 0) begin
				next_round = round_queue.pop_front();
				sample_left_x    <= next_round.left_x;
				sample_left_y    <= next_round.left_y;
				sample_right_x   <= next_round.right_x;
				sample_throttle  <= next_round.throttle;
				switch_one_level <= next_round.switch_one;
				switch_two_level <= next_round.switch_two;
				dial_one         <= next_round.dial_one;
				dial_two         <= next_round.dial_two;
				in_valid         <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Byte sink stall: a long hold when asked, otherwise a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_pending) begin
			hold_pending = 1'b0;
			hold_left    = HOLD_CYCLES - 1;
			out_stall    <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(16, 96);
			end else begin
				pattern_left--;
			end
			case (rx_pattern)
				RX_FREE:  out_stall <= 1'b0;
				RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				default:  out_stall <= (pattern_left % 7) < 4;
			endcase
		end
	end

	// Monitor: predict from taken requests first, then check the byte taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (in_valid && !in_stall) begin
				accumulate_round({sample_left_x, sample_left_y, sample_right_x, sample_throttle,
					switch_one_level, switch_two_level, dial_one, dial_two});
				rounds_taken++;
			end
			if (out_valid && !out_stall) begin
				if (frame_bytes_due.size() == 0) begin
					log_failure($sformatf("unexpected byte %02h last_byte %0b", tx_byte, last_byte));
				end else begin
					due = frame_bytes_due.pop_front();
					bytes_checked++;
					if (tx_byte !== due.code)
						log_failure($sformatf("tx_byte expected %02h, got %02h", due.code, tx_byte));
					if (last_byte !== due.last)
						log_failure($sformatf("last_byte expected %0b, got %0b", due.last, last_byte));
				end
			end
		end
	end

	// Watchdog: end the run when no handshake happens for too long
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("** joystick_frame_encoder: FAILED **");
		$finish;
	end

	initial begin
		int pick;
		cal_regs[REG_LEFT_X_OFFSET]  = CFG_OFFSET_RESET;
		cal_regs[REG_LEFT_X_RANGE]   = CFG_RANGE_RESET;
		cal_regs[REG_LEFT_Y_OFFSET]  = CFG_OFFSET_RESET;
		cal_regs[REG_LEFT_Y_RANGE]   = CFG_RANGE_RESET;
		cal_regs[REG_RIGHT_X_OFFSET] = CFG_OFFSET_RESET;
		cal_regs[REG_RIGHT_X_RANGE]  = CFG_RANGE_RESET;
		cal_regs[REG_THROTTLE_MIN]   = CFG_MIN_RESET;
		cal_regs[REG_THROTTLE_RANGE] = CFG_RANGE_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Full-scale then zero frames on reset settings; switches and dials flip on the last round
		repeat (ROUNDS - 1) push_round(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, 1, 1, 0, 0);
		push_round(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, 0, 0, 3, 7);
		repeat (ROUNDS - 1) push_round(0, 0, 0, 0, 0, 0, 3, 7);
		push_round(0, 0, 0, 0, 1, 1, 0, 0);
		settle_block();

		// Zero spans: sums on, one above and one below the centre
		for (int idx = 0; idx < CFG_COUNT; idx++)
			next_setting[idx] = is_span(CFG_IDX_W'(idx)) ? '0 : CFG_W'(ZERO_SPAN_MID);
		program_registers();
		repeat (ROUNDS - 1) push_round(2047, 2047, 2047, 2047, 1, 1, 1, 1);
		push_round(2047, 2048, 2046, 2047, 0, 1, 2, 5);
		queue_rounds(ROUND_SPREAD, 2 * ROUNDS);
		settle_block();

		// All registers at their top value
		for (int idx = 0; idx < CFG_COUNT; idx++)
			next_setting[idx] = '1;
		program_registers();
		queue_rounds(ROUND_RAILS, 2 * ROUNDS);
		queue_rounds(ROUND_SPREAD, ROUNDS);
		settle_block();

		// Zero centres with unit spans: every axis saturates
		for (int idx = 0; idx < CFG_COUNT; idx++)
			next_setting[idx] = is_span(CFG_IDX_W'(idx)) ? CFG_W'(1) : '0;
		program_registers();
		queue_rounds(ROUND_HELD, ROUNDS);
		queue_rounds(ROUND_RAILS, ROUNDS);
		settle_block();

		// Trimmed settings with a long sink hold while requests keep coming
		for (int idx = 0; idx < CFG_COUNT; idx++)
			next_setting[idx] = pick_setting(CFG_IDX_W'(idx), SET_TRIMMED);
		program_registers();
		hold_pending = 1'b1;
		repeat (3) queue_rounds(ROUND_HELD, ROUNDS);

		// Random phases; a partial frame may carry over into the next setting
		while (items_queued < ITEM_TARGET) begin
			settle_block();
			for (int idx = 0; idx < CFG_COUNT; idx++) begin
				pick = $urandom_range(0, 9);
				next_setting[idx] = pick_setting(CFG_IDX_W'(idx),
					(pick < 6) ? SET_TRIMMED : (pick < 8) ? SET_EXTREME : SET_WILD);
			end
			program_registers();
			repeat ($urandom_range(2, 4))
				queue_rounds(round_style_t'($urandom_range(0, 2)), ROUNDS);
			if ($urandom_range(0, 2) == 0)
				queue_rounds(round_style_t'($urandom_range(0, 2)), $urandom_range(1, ROUNDS - 1));
		end
		settle_block();

		$display("run covered %0d rounds and %0d frame bytes over %0d register settings,",
			rounds_taken, bytes_checked, settings_applied);
		$display("including zero and full-scale spans, a long sink hold and drained pauses");
		if (failures == 0) begin
			$display("** joystick_frame_encoder: PASSED **");
		end else begin
			$display("%0d failures", failures);
			$display("** joystick_frame_encoder: FAILED **");
		end
		$finish;
	end

endmodule
